/* rtl/core/small_aes_block_cipher_macros.svh */
// Assertion macros for the small-scale AES pipeline.
// Expect signals clk and rst_n in the scope of each use.
`ifndef SMALL_AES_BLOCK_CIPHER_MACROS_SVH
`define SMALL_AES_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define SAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define SAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Property checked at every edge, reset included.
`define SAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

/* rtl/core/sac_pkg.sv */
// Package for the small-scale AES pipeline: types, S-box and permutation tables,
// and the round functions. No dependencies.
`timescale 1ns / 1ps

package sac_pkg;

  localparam int BLOCK_W   = 64;
  localparam int NIB_N     = 16;
  localparam int NUM_KEYS  = 8;
  localparam int KEY_IDX_W = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [NUM_KEYS-1:0][BLOCK_W-1:0] key_array_t;

  typedef struct packed {
    logic valid;
    logic dir;
  } sac_ctl_t;

  localparam logic [3:0] SBOX_FWD [NIB_N] = '{
    4'h6, 4'hB, 4'h5, 4'h4, 4'h2, 4'hE, 4'h7, 4'hA,
    4'h9, 4'hD, 4'hF, 4'hC, 4'h3, 4'h1, 4'h0, 4'h8
  };
  localparam logic [3:0] SBOX_INV [NIB_N] = '{
    4'hE, 4'hD, 4'h4, 4'hC, 4'h3, 4'h2, 4'h0, 4'h6,
    4'hF, 4'h8, 4'h7, 4'h1, 4'hB, 4'h9, 4'h5, 4'hA
  };
  localparam logic [3:0] PERM_FWD [NIB_N] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };
  localparam logic [3:0] PERM_INV [NIB_N] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };
  localparam logic [3:0] MIX_FWD [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
  localparam logic [3:0] MIX_INV [4] = '{4'hE, 4'hB, 4'hD, 4'h9};

  // GF(16) multiply, reduction polynomial x^4+x+1.
  function automatic logic [3:0] gf_mul(input logic [3:0] a_in, input logic [3:0] b);
    logic [3:0] a;
    logic [3:0] acc;
    a   = a_in;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= a;
      a = {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  // S-box on every nibble combined with (inverse) ShiftRows.
  function automatic block_t sub_perm(input block_t s, input logic inv);
    block_t     t;
    logic [3:0] src;
    for (int i = 0; i < NIB_N; i++) begin
      if (inv) begin
        src = s[4*int'(PERM_INV[i]) +: 4];
        t[4*i +: 4] = SBOX_INV[src];
      end else begin
        src = s[4*int'(PERM_FWD[i]) +: 4];
        t[4*i +: 4] = SBOX_FWD[src];
      end
    end
    return t;
  endfunction

  // Circulant MixColumns over each column.
  function automatic block_t mix_cols(input block_t s, input logic inv);
    block_t     t;
    logic [3:0] acc;
    logic [1:0] ci;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          ci  = 2'(j + 4 - r);
          acc ^= gf_mul(s[4*(4*c+j) +: 4], inv ? MIX_INV[ci] : MIX_FWD[ci]);
        end
        t[4*(4*c+r) +: 4] = acc;
      end
    end
    return t;
  endfunction

endpackage

/* rtl/core/sac_keys.sv */
// Round key register file written through the configuration channel.
// Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_keys (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sac_pkg::BLOCK_W-1:0]    cfg_data,
  output sac_pkg::key_array_t            keys_o
);
  import sac_pkg::*;

  key_array_t keys_r;

  assign cfg_ready = 1'b1;
  assign keys_o    = keys_r;

  // Drop writes to indexes past the last key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_valid && (int'(cfg_index) < NUM_KEYS)) begin
      keys_r[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

endmodule

/* rtl/core/sac_round.sv */
// One registered cipher round, encrypt or decrypt chosen per item.
// Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_round (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en_i,
  input  sac_pkg::sac_ctl_t            ctl_i,
  input  logic [sac_pkg::BLOCK_W-1:0]  data_i,
  input  logic [sac_pkg::BLOCK_W-1:0]  key_enc_i,
  input  logic [sac_pkg::BLOCK_W-1:0]  key_dec_i,
  input  logic                         mix_en_i,
  output sac_pkg::sac_ctl_t            ctl_o,
  output logic [sac_pkg::BLOCK_W-1:0]  data_o
);
  import sac_pkg::*;

  logic   valid_r;
  logic   dir_r;
  block_t data_r;
  block_t data_nxt;
  block_t sp;
  block_t enc_mix;
  block_t dec_key;

  // Encrypt: sub/shift, mix, key. Decrypt: inv sub/shift, key, inv mix.
  always_comb begin
    sp       = sub_perm(data_i, ctl_i.dir);
    enc_mix  = mix_en_i ? mix_cols(sp, 1'b0) : sp;
    dec_key  = sp ^ key_dec_i;
    if (ctl_i.dir == DIR_DEC) begin
      data_nxt = mix_en_i ? mix_cols(dec_key, 1'b1) : dec_key;
    end else begin
      data_nxt = enc_mix ^ key_enc_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      dir_r  <= ctl_i.dir;
      data_r <= data_nxt;
    end
  end

  assign ctl_o.valid = valid_r;
  assign ctl_o.dir   = dir_r;
  assign data_o      = data_r;

endmodule

/* rtl/core/small_aes_block_cipher.sv */
// Small-scale AES on a 64-bit block of sixteen nibbles, one block per cycle
// sustained while out_ready holds high. The pipeline is one key-addition stage
// followed by one register stage per round; each round stage holds one S-box
// layer, one MixColumns (none in the last round) and one key addition.
// Encryption and decryption may be mixed freely item by item through
// in_direction. Every stage stalls only when it is full and the stage after
// it cannot take its content, so bubbles collapse and inputs keep flowing
// while a result waits, until the pipe is full.
// Round keys are written through the cfg channel (index 0..7, writes to
// higher indexes are dropped) and must only change while the pipe is empty.
// Depends on sac_pkg, sac_keys, sac_round and the assertion macro header.
`timescale 1ns / 1ps
`include "small_aes_block_cipher_macros.svh"

module small_aes_block_cipher #(
  parameter int NUM_ROUNDS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_direction,
  input  logic [sac_pkg::BLOCK_W-1:0]    in_block_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sac_pkg::BLOCK_W-1:0]    out_block_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sac_pkg::BLOCK_W-1:0]    cfg_data
);
  import sac_pkg::*;

  key_array_t keys;

  // Stage 0 is the whitening stage; stages 1..NUM_ROUNDS are the rounds.
  sac_ctl_t              ctl   [NUM_ROUNDS+1];
  block_t                data  [NUM_ROUNDS+1];
  logic [NUM_ROUNDS+1:0] en;
  logic [NUM_ROUNDS:0]   stage_valid;

  logic   s0_valid_r;
  logic   s0_dir_r;
  block_t s0_data_r;
  block_t s0_data_nxt;

  sac_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys_o    (keys)
  );

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NUM_ROUNDS+1] = out_ready;
    for (int k = NUM_ROUNDS; k >= 0; k--) begin
      en[k] = !ctl[k].valid || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k <= NUM_ROUNDS; k++) begin
      stage_valid[k] = ctl[k].valid;
    end
  end

  assign in_ready = en[0];

  // Encryption whitens with key 0, decryption starts from the last key.
  assign s0_data_nxt = in_block_in ^
    ((in_direction == DIR_DEC) ? keys[KEY_IDX_W'(NUM_ROUNDS)] : keys[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en[0]) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      s0_dir_r  <= in_direction;
      s0_data_r <= s0_data_nxt;
    end
  end

  assign ctl[0].valid = s0_valid_r;
  assign ctl[0].dir   = s0_dir_r;
  assign data[0]      = s0_data_r;

  // Round j uses key j for encryption and key NUM_ROUNDS-j for decryption;
  // the last round skips MixColumns in both directions.
  for (genvar j = 1; j <= NUM_ROUNDS; j++) begin : g_round
    sac_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en_i      (en[j]),
      .ctl_i     (ctl[j-1]),
      .data_i    (data[j-1]),
      .key_enc_i (keys[KEY_IDX_W'(j)]),
      .key_dec_i (keys[KEY_IDX_W'(NUM_ROUNDS - j)]),
      .mix_en_i  (j < NUM_ROUNDS),
      .ctl_o     (ctl[j]),
      .data_o    (data[j])
    );
  end

  assign out_valid     = ctl[NUM_ROUNDS].valid;
  assign out_block_out = data[NUM_ROUNDS];

  `SAC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (stage_valid == '0), "pipe not empty after reset")
  `SAC_ASSERT_IMPL(a_backpressure_full, !in_ready, &stage_valid, "input stalled while a stage is empty")
  `SAC_ASSERT_NEXT(a_s0_hold, s0_valid_r && !en[1], s0_valid_r && $stable(s0_data_r), "stalled stage 0 lost its data")

endmodule

/* verif/small_aes_block_cipher_tb.sv */
// Self-checking bench for small_aes_block_cipher: random and directed blocks in
// both directions against an in-bench cipher model. Depends on sac_pkg and the DUT.
`timescale 1ns / 1ps

module small_aes_block_cipher_tb #(
  parameter int ROUNDS = 4
);

  localparam int BW          = sac_pkg::BLOCK_W;
  localparam int IW          = sac_pkg::CFG_IDX_W;
  localparam int KEY_COUNT   = sac_pkg::NUM_KEYS;
  localparam int CFG_SPAN    = 1 << IW;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 240;

  // Substitution layers and MixColumns coefficients, kept separate from the RTL copy.
  localparam logic [3:0] SUBST_ENC [16] = '{
    4'h6, 4'hB, 4'h5, 4'h4, 4'h2, 4'hE, 4'h7, 4'hA,
    4'h9, 4'hD, 4'hF, 4'hC, 4'h3, 4'h1, 4'h0, 4'h8
  };
  localparam logic [3:0] SUBST_DEC [16] = '{
    4'hE, 4'hD, 4'h4, 4'hC, 4'h3, 4'h2, 4'h0, 4'h6,
    4'hF, 4'h8, 4'h7, 4'h1, 4'hB, 4'h9, 4'h5, 4'hA
  };
  localparam logic [3:0] MIX_ENC [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
  localparam logic [3:0] MIX_DEC [4] = '{4'hE, 4'hB, 4'hD, 4'h9};

  typedef struct packed {
    logic          dir;
    logic [BW-1:0] blk;
  } cipher_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_direction = 1'b0;
  logic [BW-1:0] in_block_in = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [BW-1:0] out_block_out;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [BW-1:0] cfg_data = '0;

  // Mirror of the round-key registers as the cipher should see them.
  logic [BW-1:0] round_keys [KEY_COUNT];

  cipher_req_t   pending_q [$];
  logic [BW-1:0] block_out_q [$];

  int send_idle_pct = 8;
  int recv_idle_pct = 45;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;

  small_aes_block_cipher #(
    .NUM_ROUNDS(ROUNDS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_direction (in_direction),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_block_out(out_block_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------

  // GF(16) product, reduction by x^4+x+1: a carry out of bit 3 folds back as 0x3.
  function automatic logic [3:0] gf16_times(input logic [3:0] x, input logic [3:0] y);
    logic [3:0] prod;
    logic [3:0] sh;
    prod = '0;
    sh   = x;
    for (int b = 0; b < 4; b++) begin
      if (y[b]) prod ^= sh;
      sh = {sh[2:0], 1'b0} ^ {2'b00, sh[3], sh[3]};
    end
    return prod;
  endfunction

  // Nibble substitution fused with ShiftRows. Row r of the column-major state
  // rotates by r columns, so destination nibble i takes source i +/- 4*(i mod 4).
  function automatic logic [BW-1:0] subst_shift(input logic [BW-1:0] s, input logic inverse);
    logic [BW-1:0] t;
    int            src;
    for (int i = 0; i < 16; i++) begin
      if (inverse) begin
        src = (i + 16 - 4 * (i % 4)) % 16;
        t[4*i +: 4] = SUBST_DEC[s[4*src +: 4]];
      end else begin
        src = (i + 4 * (i % 4)) % 16;
        t[4*i +: 4] = SUBST_ENC[s[4*src +: 4]];
      end
    end
    return t;
  endfunction

  function automatic logic [BW-1:0] mix_columns(input logic [BW-1:0] s, input logic inverse);
    logic [BW-1:0] t;
    logic [3:0]    acc;
    logic [3:0]    coef;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          coef = inverse ? MIX_DEC[(j + 4 - r) % 4] : MIX_ENC[(j + 4 - r) % 4];
          acc ^= gf16_times(s[4*(4*c+j) +: 4], coef);
        end
        t[4*(4*c+r) +: 4] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [BW-1:0] cipher_block(input logic dir, input logic [BW-1:0] blk);
    logic [BW-1:0] s;
    if (dir == sac_pkg::DIR_DEC) begin
      s = blk ^ round_keys[ROUNDS];
      for (int r = ROUNDS - 1; r > 0; r--) begin
        s = subst_shift(s, 1'b1) ^ round_keys[r];
        s = mix_columns(s, 1'b1);
      end
      s = subst_shift(s, 1'b1) ^ round_keys[0];
    end else begin
      s = blk ^ round_keys[0];
      for (int r = 1; r < ROUNDS; r++) begin
        s = mix_columns(subst_shift(s, 1'b0), 1'b0) ^ round_keys[r];
      end
      s = subst_shift(s, 1'b0) ^ round_keys[ROUNDS];
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: predict on every accepted transfer, then offer the next
  // pending block or idle. Valid only drops after a transfer or while idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cipher_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        block_out_q.push_back(cipher_block(in_direction, in_block_in));
      end
      // Slot is free once the current block transfers, or when nothing is offered.
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          req = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_direction <= req.dir;
          in_block_in  <= req.blk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest prediction, then
  // choose ready for the next edge. A pending hold-off forces ready low.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [BW-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (block_out_q.size() == 0) begin
          $display("%0t: unexpected block_out, expected none actual %h", $time, out_block_out);
          mismatches++;
        end else begin
          want = block_out_q.pop_front();
          if (out_block_out !== want) begin
            $display("%0t: block_out mismatch, expected %h actual %h",
                     $time, want, out_block_out);
            mismatches++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted down here so the pipe fills and backs up.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Write one register and wait for its transfer. Leave cfg_valid high so
  // back-to-back writes never drop and raise it in the same step; the caller
  // lowers it after the batch. Indexes past the key file are dropped.
  task automatic write_reg(input int idx, input logic [BW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= IW'(idx);
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < KEY_COUNT) round_keys[idx] = val;
  endtask

  task automatic push_block(input logic dir, input logic [BW-1:0] blk);
    cipher_req_t req;
    req.dir = dir;
    req.blk = blk;
    pending_q.push_back(req);
  endtask

  // Wait until every block is sent and every result checked; end on a rising edge.
  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || block_out_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    logic          dir;
    logic [BW-1:0] blk;
    for (int k = 0; k < n; k++) begin
      dir = $urandom_range(1, 0) ? sac_pkg::DIR_DEC : sac_pkg::DIR_ENC;
      // Mostly dense random blocks, with a sprinkling of extremes.
      case ($urandom_range(15, 0))
        0:       blk = '0;
        1:       blk = '1;
        2:       blk = BW'(64'hF) << (4 * $urandom_range(15, 0));
        default: blk = {$urandom, $urandom};
      endcase
      push_block(dir, blk);
    end
  endtask

  initial begin
    for (int k = 0; k < KEY_COUNT; k++) round_keys[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero keys straight out of reset.
    send_idle_pct = 8;
    recv_idle_pct = 45;
    push_block(sac_pkg::DIR_ENC, '0);
    push_block(sac_pkg::DIR_DEC, '0);
    push_block(sac_pkg::DIR_ENC, '1);
    push_block(sac_pkg::DIR_DEC, '1);
    push_block(sac_pkg::DIR_ENC, 64'hFEDC_BA98_7654_3210);
    push_block(sac_pkg::DIR_DEC, 64'hFEDC_BA98_7654_3210);
    drain();

    // Random key file, then junk at indexes past the key file, which must be dropped.
    for (int k = 0; k < KEY_COUNT; k++) write_reg(k, {$urandom, $urandom});
    for (int k = KEY_COUNT; k < CFG_SPAN; k++) write_reg(k, '1);
    cfg_valid <= 1'b0;
    push_block(sac_pkg::DIR_ENC, 64'h0123_4567_89AB_CDEF);
    push_block(sac_pkg::DIR_DEC, 64'h0123_4567_89AB_CDEF);
    push_block(sac_pkg::DIR_ENC, 64'h5555_5555_5555_5555);
    push_block(sac_pkg::DIR_DEC, 64'hAAAA_AAAA_AAAA_AAAA);
    push_block(sac_pkg::DIR_ENC, 64'hF000_0000_0000_0000);
    push_block(sac_pkg::DIR_DEC, 64'h0000_0000_0000_000F);
    push_block(sac_pkg::DIR_ENC, '1);
    push_block(sac_pkg::DIR_DEC, '0);
    drain();

    // All-ones keys.
    for (int k = 0; k < KEY_COUNT; k++) write_reg(k, '1);
    cfg_valid <= 1'b0;
    push_block(sac_pkg::DIR_ENC, '0);
    push_block(sac_pkg::DIR_DEC, '0);
    push_block(sac_pkg::DIR_ENC, '1);
    push_block(sac_pkg::DIR_DEC, '1);
    drain();

    // Change only the keys beyond the last round: results must not move.
    for (int k = ROUNDS + 1; k < KEY_COUNT; k++) write_reg(k, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    push_block(sac_pkg::DIR_ENC, '0);
    push_block(sac_pkg::DIR_DEC, '1);
    push_block(sac_pkg::DIR_ENC, 64'h0123_4567_89AB_CDEF);
    push_block(sac_pkg::DIR_DEC, 64'hFEDC_BA98_7654_3210);
    drain();

    // Random, sender busy and receiver lazy; stall the output early so the pipe backs up.
    for (int k = 0; k < KEY_COUNT; k++) write_reg(k, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    queue_random(250);
    hold_left <= HOLD_CYCLES;
    drain();

    // Random, sender lazy and receiver eager; mix extreme and random keys.
    for (int k = 0; k < KEY_COUNT; k++) begin
      case ($urandom_range(2, 0))
        0:       write_reg(k, '0);
        1:       write_reg(k, '1);
        default: write_reg(k, {$urandom, $urandom});
      endcase
    end
    cfg_valid <= 1'b0;
    send_idle_pct = 45;
    recv_idle_pct = 8;
    queue_random(250);
    drain();

    // Random at full rate on both sides.
    for (int k = 0; k < KEY_COUNT; k++) write_reg(k, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(250);
    drain();

    // Let anything stray fall out of the pipe before the verdict.
    repeat (ROUNDS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
